/* sv/assert_macros.svh */
// assertion helpers, clocked on clk; NFA_ASSERT is off while rst_n is low, NFA_ASSERT_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define NFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define NFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/nfa_ssm_pkg.sv */
package nfa_ssm_pkg;

  localparam int STATE_W    = 5;
  localparam int SYM_W      = 7;
  localparam int SET_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [SYM_W-1:0] SYM_FIRST = 7'h21;
  localparam logic [SYM_W-1:0] SYM_LAST  = 7'h7E;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_START  = 2'd2,
    MODE_FEED   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXISTING  = 3'd0,
    REG_INITIAL   = 3'd1,
    REG_FINAL     = 3'd2,
    REG_ALPH_LOW  = 3'd3,
    REG_ALPH_HIGH = 3'd4
  } cfg_reg_t;

endpackage

/* sv/nfa_ssm_if.sv */
interface nfa_ssm_in_if import nfa_ssm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [STATE_W-1:0] source_state;
  logic [STATE_W-1:0] dest_state;
  logic [SYM_W-1:0]   symbol;

  modport source (output valid, mode, source_state, dest_state, symbol, input ready);
  modport sink   (input valid, mode, source_state, dest_state, symbol, output ready);
endinterface

interface nfa_ssm_out_if import nfa_ssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op_ok;
  logic             accepted;
  logic [SET_W-1:0] active_set;

  modport source (output valid, op_ok, accepted, active_set, input ready);
  modport sink   (input valid, op_ok, accepted, active_set, output ready);
endinterface

/* sv/nfa_state_set_matcher_top.sv */
// start goes from the input transfer straight to S_DONE, add or remove through S_EDIT_RD and
// S_EDIT_WR, a symbol through S_FEED (one transition row read per state slot, min(NUM_STATES,32) slots) and S_FEED_END
// one item in flight: no new input transfer is taken until S_DONE has loaded the result,
// and S_DONE holds while an earlier result still waits for out_ch.ready
// reset (rst_n low, synchronous) zeroes the control and config registers and the active set, then a clearing
// pass writes zero to all NUM_STATES*NUM_SYMBOLS rows, one per cycle, input not ready
`include "assert_macros.svh"

module nfa_state_set_matcher_top import nfa_ssm_pkg::*; #(
  parameter int NUM_STATES  = 32,
  parameter int NUM_SYMBOLS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  nfa_ssm_in_if.sink            in_ch,
  nfa_ssm_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = NUM_STATES * NUM_SYMBOLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ES     = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;
  localparam int SW     = $clog2(ES);
  localparam logic [SET_W-1:0] LIMIT_MASK =
    (NUM_STATES >= SET_W) ? {SET_W{1'b1}} : SET_W'((64'd1 << NUM_STATES) - 64'd1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDIT_RD,
    S_EDIT_WR,
    S_FEED,
    S_FEED_END,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]      s_cnt_r, s_cnt_nxt;
  logic               take_r, take_nxt;
  mode_t              mode_r, mode_nxt;
  logic [STATE_W-1:0] src_r, src_nxt;
  logic [STATE_W-1:0] dst_r, dst_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [SET_W-1:0]   cur_r, cur_nxt;
  logic [SET_W-1:0]   acc_r, acc_nxt;
  logic               ok_r, ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic [SET_W-1:0]   out_set_r, out_set_nxt;

  logic [SET_W-1:0]   existing_r, initial_r, final_r;
  logic [63:0]        alph_low_r, alph_high_r;

  logic [SET_W-1:0]   mem [DEPTH];
  logic [SET_W-1:0]   rdata_r;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [SET_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]  row_addr;
  logic [STATE_W-1:0] row_state;

  logic [127:0]       alph_vec;
  logic [SET_W-1:0]   dst_mask;
  logic               bit_set;
  logic               src_in, dst_in, sym_in_store, sym_print, sym_in_alph;
  logic               add_ok, rem_ok, edit_ok;
  logic [SET_W-1:0]   acc_sum;

  // shared row address for edits and feed scans
  always_comb begin
    row_state = (state_r == S_FEED) ? STATE_W'(s_cnt_r) : src_r;
    row_addr  = ADDR_W'(ADDR_W'(row_state) * ADDR_W'(NUM_SYMBOLS)) + ADDR_W'(sym_r);
  end

  always_comb begin
    alph_vec     = {alph_high_r, alph_low_r};
    dst_mask     = SET_W'(1) << dst_r;
    bit_set      = rdata_r[dst_r];
    src_in       = 32'(src_r) < NUM_STATES;
    dst_in       = 32'(dst_r) < NUM_STATES;
    sym_in_store = 32'(sym_r) < NUM_SYMBOLS;
    sym_print    = (sym_r >= SYM_FIRST) && (sym_r <= SYM_LAST);
    sym_in_alph  = alph_vec[sym_r];
    add_ok       = src_in && existing_r[src_r] && dst_in && existing_r[dst_r] &&
                   sym_print && sym_in_store && sym_in_alph && !bit_set;
    rem_ok       = src_in && sym_in_store && bit_set;
    edit_ok      = (mode_r == MODE_ADD) ? add_ok : rem_ok;
    acc_sum      = acc_r | (take_r ? rdata_r : '0);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = (mode_r == MODE_ADD) ? (rdata_r | dst_mask) : (rdata_r & ~dst_mask);

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    s_cnt_nxt     = s_cnt_r;
    take_nxt      = take_r;
    mode_nxt      = mode_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    sym_nxt       = sym_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    ok_nxt        = ok_r;
    out_ok_nxt    = out_ok_r;
    out_acc_nxt   = out_acc_r;
    out_set_nxt   = out_set_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = mode_t'(in_ch.mode);
          src_nxt   = in_ch.source_state;
          dst_nxt   = in_ch.dest_state;
          sym_nxt   = in_ch.symbol;
          ok_nxt    = 1'b0;
          s_cnt_nxt = '0;
          take_nxt  = 1'b0;
          acc_nxt   = '0;
          case (mode_t'(in_ch.mode))
            MODE_ADD, MODE_REMOVE: state_nxt = S_EDIT_RD;
            MODE_START: begin
              cur_nxt   = initial_r & LIMIT_MASK;
              state_nxt = S_DONE;
            end
            MODE_FEED: state_nxt = S_FEED;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_EDIT_RD: begin
        state_nxt = S_EDIT_WR;
      end
      S_EDIT_WR: begin
        mem_we    = edit_ok;
        ok_nxt    = edit_ok;
        state_nxt = S_DONE;
      end
      S_FEED: begin
        acc_nxt   = acc_sum;
        take_nxt  = cur_r[5'(s_cnt_r)] && sym_in_store;
        s_cnt_nxt = s_cnt_r + SW'(1);
        if (s_cnt_r == SW'(ES - 1)) begin
          state_nxt = S_FEED_END;
        end
      end
      S_FEED_END: begin
        cur_nxt   = acc_sum & LIMIT_MASK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_acc_nxt   = |(cur_r & final_r);
          out_set_nxt   = cur_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      s_cnt_r     <= '0;
      take_r      <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s_cnt_r     <= s_cnt_nxt;
      take_r      <= take_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r    <= mode_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    sym_r     <= sym_nxt;
    acc_r     <= acc_nxt;
    ok_r      <= ok_nxt;
    out_ok_r  <= out_ok_nxt;
    out_acc_r <= out_acc_nxt;
    out_set_r <= out_set_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      existing_r  <= '0;
      initial_r   <= '0;
      final_r     <= '0;
      alph_low_r  <= '0;
      alph_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_EXISTING:  existing_r  <= cfg_data[SET_W-1:0];
        REG_INITIAL:   initial_r   <= cfg_data[SET_W-1:0];
        REG_FINAL:     final_r     <= cfg_data[SET_W-1:0];
        REG_ALPH_LOW:  alph_low_r  <= cfg_data;
        REG_ALPH_HIGH: alph_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // transition rows, at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[row_addr];
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.op_ok      = out_ok_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.active_set = out_set_r;

  `NFA_ASSERT(a_no_accept_in_clear, (state_r == S_CLEAR) |-> !in_ch.ready, "input taken during clear")
  `NFA_ASSERT(a_write_states, mem_we |-> (state_r == S_CLEAR || state_r == S_EDIT_WR), "stray row write")
  `NFA_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result without finish")
  `NFA_ASSERT_ALWAYS(a_set_in_range, (cur_r & ~LIMIT_MASK) == '0, "active state out of range")

endmodule
